[src/assert_macros.svh]
// Assertion helpers shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define LTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/lte_pkg.sv]
`timescale 1ns / 1ps

package lte_pkg;

    // Request opcodes.
    localparam logic OP_PUTC  = 1'b0;
    localparam logic OP_XPUTC = 1'b1;

    // Longest escape string in bytes.
    localparam int STR_BYTES = 22;
    localparam int NUM_STR   = 23;

    typedef logic [8*STR_BYTES-1:0] str_vec_t;
    typedef logic [4:0] str_id_t;
    typedef logic [4:0] str_pos_t;

    // Escape string identifiers.
    localparam str_id_t S_CHAR34  = 5'd0;
    localparam str_id_t S_CHAR60  = 5'd1;
    localparam str_id_t S_CHAR62  = 5'd2;
    localparam str_id_t S_CHAR92  = 5'd3;
    localparam str_id_t S_CHAR94  = 5'd4;
    localparam str_id_t S_CHAR124 = 5'd5;
    localparam str_id_t S_CHAR126 = 5'd6;
    localparam str_id_t S_BULLET  = 5'd7;
    localparam str_id_t S_HYPHEN  = 5'd8;
    localparam str_id_t S_SECT    = 5'd9;
    localparam str_id_t S_COPY    = 5'd10;
    localparam str_id_t S_ORDF    = 5'd11;
    localparam str_id_t S_LNOT    = 5'd12;
    localparam str_id_t S_MACRON  = 5'd13;
    localparam str_id_t S_PM      = 5'd14;
    localparam str_id_t S_SUP2    = 5'd15;
    localparam str_id_t S_SUP3    = 5'd16;
    localparam str_id_t S_MU      = 5'd17;
    localparam str_id_t S_PARA    = 5'd18;
    localparam str_id_t S_SUP1    = 5'd19;
    localparam str_id_t S_ORDM    = 5'd20;
    localparam str_id_t S_TIMES   = 5'd21;
    localparam str_id_t S_DIV     = 5'd22;

    // Strings are right justified, so unused leading bytes are zero.
    localparam str_vec_t STR_ROM [NUM_STR] = '{
        "\\texttt{\\char34}",
        "\\texttt{\\char60}",
        "\\texttt{\\char62}",
        "\\texttt{\\char92}",
        "\\texttt{\\char94}",
        "\\texttt{\\char124}",
        "\\texttt{\\char126}",
        "$\\bullet$",
        "{-}",
        "{\\textsection}",
        "{\\textcopyright}",
        "{\\tt\\textordfeminine}",
        "{\\textlnot}",
        "{\\textasciimacron}",
        "{\\textpm}",
        "{\\texttwosuperior}",
        "{\\textthreesuperior}",
        "{\\textmu}",
        "{\\textparagraph}",
        "{\\textonesuperior}",
        "{\\tt\\textordmasculine}",
        "{\\texttimes}",
        "{\\textdiv}"
    };

    // How the body of one request is produced.
    typedef enum logic [1:0] {
        K_RAW,
        K_ESC,
        K_STR
    } body_kind_t;

    typedef struct packed {
        body_kind_t kind;
        logic [7:0] raw;
        str_id_t    sid;
    } body_cls_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PEND,
        ST_BODY
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_pend;
        logic load_body;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drop;
        logic has_pend;
        logic out_free;
        logic body_last;
    } dp_stat_t;

    // Space, tab, newline, vertical tab, form feed and carriage return.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // Index of the last byte of an escape string.
    function automatic str_pos_t str_last(input str_id_t id);
        str_vec_t v;
        str_pos_t cnt;
        v   = STR_ROM[id];
        cnt = '0;
        for (int i = 0; i < STR_BYTES; i++) begin
            if (v[8*i +: 8] != 8'd0) begin
                cnt = cnt + 5'd1;
            end
        end
        return cnt - 5'd1;
    endfunction

    // Decide how one byte is escaped.
    function automatic body_cls_t classify(input logic [7:0] c);
        body_cls_t r;
        r.kind = K_RAW;
        r.raw  = c;
        r.sid  = S_BULLET;
        case (c)
            "%", "$", "#", "_", "&", "{", "}": r.kind = K_ESC;
            "\"": begin r.kind = K_STR; r.sid = S_CHAR34;  end
            "<":  begin r.kind = K_STR; r.sid = S_CHAR60;  end
            ">":  begin r.kind = K_STR; r.sid = S_CHAR62;  end
            "\\": begin r.kind = K_STR; r.sid = S_CHAR92;  end
            "^":  begin r.kind = K_STR; r.sid = S_CHAR94;  end
            "|":  begin r.kind = K_STR; r.sid = S_CHAR124; end
            "~":  begin r.kind = K_STR; r.sid = S_CHAR126; end
            "-":  begin r.kind = K_STR; r.sid = S_HYPHEN;  end
            8'h09, 8'h0a: r.kind = K_RAW;
            8'ha1: r.raw = "!";
            8'hbf: r.raw = "?";
            8'hd0: r.raw = "D";
            8'hde: r.raw = "T";
            8'hf0: r.raw = "d";
            8'hfe: r.raw = "t";
            8'ha7: begin r.kind = K_STR; r.sid = S_SECT;    end
            8'ha9: begin r.kind = K_STR; r.sid = S_COPY;    end
            8'haa: begin r.kind = K_STR; r.sid = S_ORDF;    end
            8'hac: begin r.kind = K_STR; r.sid = S_LNOT;    end
            8'had: begin r.kind = K_STR; r.sid = S_HYPHEN;  end
            8'haf: begin r.kind = K_STR; r.sid = S_MACRON;  end
            8'hb1: begin r.kind = K_STR; r.sid = S_PM;      end
            8'hb2: begin r.kind = K_STR; r.sid = S_SUP2;    end
            8'hb3: begin r.kind = K_STR; r.sid = S_SUP3;    end
            8'hb5: begin r.kind = K_STR; r.sid = S_MU;      end
            8'hb6: begin r.kind = K_STR; r.sid = S_PARA;    end
            8'hb9: begin r.kind = K_STR; r.sid = S_SUP1;    end
            8'hba: begin r.kind = K_STR; r.sid = S_ORDM;    end
            8'hd7: begin r.kind = K_STR; r.sid = S_TIMES;   end
            8'hf7: begin r.kind = K_STR; r.sid = S_DIV;     end
            default: begin
                // Remaining control codes and the upper control range.
                if ((c < 8'd32) || ((c >= 8'd127) && (c < 8'd160))) begin
                    r.kind = K_STR;
                    r.sid  = S_BULLET;
                end
            end
        endcase
        return r;
    endfunction

endpackage

[src/lte_in_if.sv]
`timescale 1ns / 1ps

interface lte_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] in_byte;

    modport source (output valid, output opcode, output in_byte, input ready);
    modport sink (input valid, input opcode, input in_byte, output ready);
endinterface

[src/lte_out_if.sv]
`timescale 1ns / 1ps

interface lte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

[src/lte_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lte_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lte_pkg::dp_stat_t  stat,
    output lte_pkg::ctrl_cmd_t cmd
);

    lte_pkg::ctrl_state_t state_reg;
    lte_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lte_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.load_pend = 1'b0;
        cmd.load_body = 1'b0;
        case (state_reg)
            lte_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.drop)
                    begin
                        state_next = stat.has_pend ? lte_pkg::ST_PEND : lte_pkg::ST_BODY;
                    end
                end
            end
            lte_pkg::ST_PEND:
            begin
                if (stat.out_free)
                begin
                    cmd.load_pend = 1'b1;
                    state_next    = lte_pkg::ST_BODY;
                end
            end
            lte_pkg::ST_BODY:
            begin
                if (stat.out_free)
                begin
                    cmd.load_body = 1'b1;
                    if (stat.body_last)
                    begin
                        state_next = lte_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lte_pkg::ST_IDLE;
            end
        endcase
    end

    // A request that yields nothing leaves the controller ready.
    `LTE_ASSERT(a_drop_idle, clk, rst_n, (cmd.accept && stat.drop) |=> (state_reg == lte_pkg::ST_IDLE), "dropped request left idle")
    // The pending whitespace byte is always followed by the body.
    `LTE_ASSERT(a_pend_body, clk, rst_n, cmd.load_pend |=> (state_reg == lte_pkg::ST_BODY), "pending space not followed by body")
    // The last body byte ends the request.
    `LTE_ASSERT(a_last_idle, clk, rst_n, (cmd.load_body && stat.body_last) |=> in_ready, "controller busy after last byte")

endmodule

[src/lte_datapath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lte_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_opcode,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last,
    input  lte_pkg::ctrl_cmd_t cmd,
    output lte_pkg::dp_stat_t  stat
);

    // Whitespace state.
    logic                   skip_reg;
    logic                   skip_next;
    logic [7:0]             pend_reg;
    logic [7:0]             pend_next;

    // Current request body.
    lte_pkg::body_kind_t    kind_reg;
    logic [7:0]             raw_reg;
    lte_pkg::str_id_t       sid_reg;
    lte_pkg::str_pos_t      cnt_reg;
    lte_pkg::str_pos_t      pos_reg;
    logic [7:0]             pend_out_reg;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;

    lte_pkg::body_cls_t     cls;
    logic                   in_ws;
    lte_pkg::str_pos_t      str_idx;
    logic [7:0]             body_byte;
    logic                   body_last;
    lte_pkg::str_vec_t      str_vec;

    assign cls   = lte_pkg::classify(in_byte);
    assign in_ws = lte_pkg::is_ws(in_byte);

    // Whitespace handling decides whether a request yields any bytes.
    always_comb
    begin
        skip_next      = skip_reg;
        pend_next      = pend_reg;
        stat.drop      = 1'b0;
        stat.has_pend  = 1'b0;
        stat.body_last = body_last;
        stat.out_free  = !out_valid_reg || out_ready;
        if (in_opcode == lte_pkg::OP_PUTC)
        begin
            if (skip_reg && in_ws)
            begin
                stat.drop = 1'b1;
            end
            else
            begin
                skip_next = 1'b0;
            end
        end
        else
        begin
            if (in_ws)
            begin
                stat.drop = 1'b1;
                if (!skip_reg)
                begin
                    skip_next = 1'b1;
                    pend_next = in_byte;
                end
            end
            else
            begin
                stat.has_pend = (pend_reg != 8'd0);
                skip_next     = 1'b0;
                pend_next     = 8'd0;
            end
        end
    end

    // Select the next body byte.
    assign str_idx = cnt_reg - pos_reg;
    assign str_vec = lte_pkg::STR_ROM[sid_reg];

    always_comb
    begin
        case (kind_reg)
            lte_pkg::K_RAW: body_byte = raw_reg;
            lte_pkg::K_ESC: body_byte = (pos_reg == 5'd0) ? 8'h5c : raw_reg;
            lte_pkg::K_STR: body_byte = str_vec[{str_idx, 3'b000} +: 8];
            default:        body_byte = raw_reg;
        endcase
    end

    assign body_last = (pos_reg == cnt_reg);

    // State and body registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
            pend_reg <= 8'd0;
            kind_reg <= lte_pkg::K_RAW;
            cnt_reg  <= '0;
            pos_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            skip_reg <= skip_next;
            pend_reg <= pend_next;
            kind_reg <= cls.kind;
            pos_reg  <= '0;
            case (cls.kind)
                lte_pkg::K_RAW: cnt_reg <= 5'd0;
                lte_pkg::K_ESC: cnt_reg <= 5'd1;
                lte_pkg::K_STR: cnt_reg <= lte_pkg::str_last(cls.sid);
                default:        cnt_reg <= 5'd0;
            endcase
        end
        else if (cmd.load_body && !body_last)
        begin
            pos_reg <= pos_reg + 5'd1;
        end
    end

    // Body payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            raw_reg      <= cls.raw;
            sid_reg      <= cls.sid;
            pend_out_reg <= pend_reg;
        end
    end

    // Output register control.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_pend || cmd.load_body)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_pend)
        begin
            out_byte_reg <= pend_out_reg;
            out_last_reg <= 1'b0;
        end
        else if (cmd.load_body)
        begin
            out_byte_reg <= body_byte;
            out_last_reg <= body_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // The body position never runs past the last byte.
    `LTE_ASSERT(a_pos_range, clk, rst_n, pos_reg <= cnt_reg, "body position past last byte")
    // The pending byte is either empty or a whitespace code.
    `LTE_ASSERT_ALWAYS(a_pend_ws, clk, (!rst_n) || (pend_reg == 8'd0) || lte_pkg::is_ws(pend_reg), "pending byte is not whitespace")
    // The last body byte reaches the output flagged as last.
    `LTE_ASSERT(a_last_out, clk, rst_n, (cmd.load_body && body_last) |=> (out_valid_reg && out_last_reg), "last byte not flagged")

endmodule

[src/latex_text_escape_encoder_core.sv]
`timescale 1ns / 1ps
// Channel   Modport   Payload              Role
// in_ch     sink      opcode, in_byte      one character request per transfer
// out_ch    source    out_byte, out_last   one escaped text byte per transfer
//
// A request is taken, then its bytes leave at one per cycle while out_ch is ready; a request
// yields 0 to 23 bytes (a pending whitespace byte plus the longest escape string).
// The byte rate is set by the single output register that the sequencer fills.
// A whitespace request that yields nothing leaves the controller idle.
// Reset clears the whitespace state and the controller; no clearing pass is needed.
// A stalled output holds the sequencer; a new request is taken while the last byte waits.

module latex_text_escape_encoder_core (
    input logic       clk,
    input logic       rst_n,
    lte_in_if.sink    in_ch,
    lte_out_if.source out_ch
);

    lte_pkg::ctrl_cmd_t cmd;
    lte_pkg::dp_stat_t  stat;

    // Sequencing control.
    lte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Escape datapath and output register.
    lte_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_opcode (in_ch.opcode),
        .in_byte   (in_ch.in_byte),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_byte  (out_ch.out_byte),
        .out_last  (out_ch.out_last),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[bench/tb_latex_text_escape_encoder_core.sv]
`timescale 1ns / 1ps

module tb_latex_text_escape_encoder_core;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Quiet cycles after the last byte, beyond the longest run of one request.
    localparam int TAIL_CYCLES = 40;
    // Random requests that produce text, per idling phase.
    localparam int ITEMS_PER_PHASE = 60;

    localparam logic [7:0] LATIN_MAPPED [21] = '{
        8'ha1, 8'ha7, 8'ha9, 8'haa, 8'hac, 8'had, 8'haf, 8'hb1, 8'hb2, 8'hb3, 8'hb5,
        8'hb6, 8'hb9, 8'hba, 8'hbf, 8'hd0, 8'hd7, 8'hde, 8'hf0, 8'hf7, 8'hfe
    };

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } text_byte_t;

    // A request whose output is spelled out by hand rather than predicted.
    typedef struct {
        bit    typed;
        string text;
    } typed_run_t;

    typedef struct {
        logic       op;
        logic [7:0] ch;
        bit         typed;
        string      text;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lte_in_if  in_ch ();
    lte_out_if out_ch ();

    latex_text_escape_encoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // Whitespace state of the encoder as the checker sees it.
    logic       skip_blank;
    logic [7:0] held_blank;

    text_byte_t expected_text [$];
    typed_run_t typed_runs [$];
    stim_row_t  stim_table [$];

    int errors;
    int idle_cycles;
    int text_requests;
    int send_idle_pct;
    int recv_stall_pct;

    always #1 clk = ~clk;

    function automatic bit is_blank(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        expected_text.push_back('{value: b, last: 1'b0});
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i]);
        end
    endfunction

    // Decimal code without leading zeros.
    function automatic void push_decimal(input logic [7:0] c);
        if (c >= 8'd100)
        begin
            push_byte("0" + c / 8'd100);
        end
        if (c >= 8'd10)
        begin
            push_byte("0" + (c / 8'd10) % 8'd10);
        end
        push_byte("0" + c % 8'd10);
    endfunction

    // Flag the final byte of the run that started at index start.
    function automatic void mark_last(input int start);
        text_byte_t tail;
        if (expected_text.size() > start)
        begin
            tail = expected_text.pop_back();
            tail.last = 1'b1;
            expected_text.push_back(tail);
        end
    endfunction

    // LaTeX-safe spelling of one Latin-1 byte.
    function automatic void push_escaped(input logic [7:0] c);
        case (c)
            "%", "$", "#", "_", "&", "{", "}":
            begin
                push_byte("\\");
                push_byte(c);
            end
            "^", "~", "\\", "|", "<", ">", "\"":
            begin
                push_text("\\texttt{\\char");
                push_decimal(c);
                push_byte("}");
            end
            "-":          push_text("{-}");
            8'h09, 8'h0a: push_byte(c);
            8'ha1:        push_text("!");
            8'ha7:        push_text("{\\textsection}");
            8'ha9:        push_text("{\\textcopyright}");
            8'haa:        push_text("{\\tt\\textordfeminine}");
            8'hac:        push_text("{\\textlnot}");
            8'had:        push_text("{-}");
            8'haf:        push_text("{\\textasciimacron}");
            8'hb1:        push_text("{\\textpm}");
            8'hb2:        push_text("{\\texttwosuperior}");
            8'hb3:        push_text("{\\textthreesuperior}");
            8'hb5:        push_text("{\\textmu}");
            8'hb6:        push_text("{\\textparagraph}");
            8'hb9:        push_text("{\\textonesuperior}");
            8'hba:        push_text("{\\tt\\textordmasculine}");
            8'hbf:        push_text("?");
            8'hd0:        push_text("D");
            8'hd7:        push_text("{\\texttimes}");
            8'hde:        push_text("T");
            8'hf0:        push_text("d");
            8'hf7:        push_text("{\\textdiv}");
            8'hfe:        push_text("t");
            default:
            begin
                // Control codes and the upper control range print as a bullet.
                if ((c < 8'd32) || ((c >= 8'd127) && (c < 8'd160)))
                begin
                    push_text("$\\bullet$");
                end
                else
                begin
                    push_byte(c);
                end
            end
        endcase
    endfunction

    // Expected text for one request; updates the whitespace state.
    function automatic void encode_request(input logic op, input logic [7:0] ch);
        int start;
        start = expected_text.size();
        if (op == lte_pkg::OP_PUTC)
        begin
            if (skip_blank && is_blank(ch))
            begin
                return;
            end
            skip_blank = 1'b0;
            push_escaped(ch);
        end
        else
        begin
            if (is_blank(ch))
            begin
                if (!skip_blank)
                begin
                    skip_blank = 1'b1;
                    held_blank = ch;
                end
                return;
            end
            if (held_blank != 8'd0)
            begin
                push_byte(held_blank);
            end
            skip_blank = 1'b0;
            held_blank = 8'd0;
            push_escaped(ch);
        end
        mark_last(start);
    endfunction

    // Random byte, weighted toward whitespace, specials and mapped codes.
    function automatic logic [7:0] pick_char();
        int    roll;
        int    n;
        string specials;
        specials = "%$#_&{}^~\\|<>\"-";
        roll = $urandom_range(99);
        if (roll < 25)
        begin
            n = $urandom_range(5);
            return (n == 0) ? 8'd32 : 8'(8 + n);
        end
        if (roll < 45)
        begin
            return specials[$urandom_range(specials.len() - 1)];
        end
        if (roll < 60)
        begin
            return LATIN_MAPPED[$urandom_range(20)];
        end
        if (roll < 70)
        begin
            return ($urandom_range(1) == 0) ? 8'($urandom_range(31))
                                             : 8'($urandom_range(159, 127));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic void add_row(input logic op, input logic [7:0] ch,
                                    input bit typed, input string text);
        stim_table.push_back('{op: op, ch: ch, typed: typed, text: text});
    endfunction

    // Present one request at a falling edge and hold it until it is taken.
    task automatic send_request(input logic op, input logic [7:0] ch,
                                input bit typed, input string text);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        typed_runs.push_back('{typed: typed, text: text});
        in_ch.valid   = 1'b1;
        in_ch.opcode  = op;
        in_ch.in_byte = ch;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on each taken request, then check each delivered byte.
    always @(posedge clk)
    begin
        typed_run_t note;
        text_byte_t want;
        int         start;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                note.typed = 1'b0;
                note.text  = "";
                if (typed_runs.size() != 0)
                begin
                    note = typed_runs.pop_front();
                end
                start = expected_text.size();
                encode_request(in_ch.opcode, in_ch.in_byte);
                if (expected_text.size() > start)
                begin
                    text_requests++;
                end
                if (note.typed)
                begin
                    while (expected_text.size() > start)
                    begin
                        void'(expected_text.pop_back());
                    end
                    push_text(note.text);
                    mark_last(start);
                end
            end

            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("unexpected byte %h last %b", out_ch.out_byte,
                                 out_ch.out_last);
                    end
                    errors++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if ((out_ch.out_byte !== want.value) || (out_ch.out_last !== want.last))
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                                     want.value, want.last, out_ch.out_byte, out_ch.out_last);
                        end
                        errors++;
                    end
                end
            end

            // Hang detection.
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int target;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.opcode   = lte_pkg::OP_PUTC;
        in_ch.in_byte  = 8'd0;
        out_ch.ready   = 1'b0;
        skip_blank     = 1'b0;
        held_blank     = 8'd0;
        errors         = 0;
        idle_cycles    = 0;
        text_requests  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // Directed requests: extremes, every escape class and whitespace handling.
        add_row(lte_pkg::OP_PUTC,  8'h00, 1, "$\\bullet$");
        add_row(lte_pkg::OP_PUTC,  8'hff, 1, "\377");
        add_row(lte_pkg::OP_PUTC,  " ",   1, " ");
        add_row(lte_pkg::OP_PUTC,  "%",   1, "\\%");
        add_row(lte_pkg::OP_PUTC,  "~",   1, "\\texttt{\\char126}");
        add_row(lte_pkg::OP_PUTC,  "\"",  0, "");
        add_row(lte_pkg::OP_PUTC,  "-",   1, "{-}");
        add_row(lte_pkg::OP_PUTC,  8'had, 0, "");
        add_row(lte_pkg::OP_PUTC,  8'h09, 1, "\t");
        add_row(lte_pkg::OP_PUTC,  8'h0a, 0, "");
        add_row(lte_pkg::OP_PUTC,  8'h7f, 0, "");
        add_row(lte_pkg::OP_PUTC,  8'ha0, 0, "");
        add_row(lte_pkg::OP_PUTC,  8'ha1, 0, "");
        add_row(lte_pkg::OP_PUTC,  8'haa, 0, "");
        // A space run collapses; the held space precedes the longest string.
        add_row(lte_pkg::OP_XPUTC, " ",   1, "");
        add_row(lte_pkg::OP_XPUTC, 8'h09, 0, "");
        add_row(lte_pkg::OP_XPUTC, 8'hba, 0, "");
        // Plain put clears the skip flag but leaves the held whitespace byte alone.
        add_row(lte_pkg::OP_XPUTC, 8'h0d, 0, "");
        add_row(lte_pkg::OP_PUTC,  " ",   0, "");
        add_row(lte_pkg::OP_PUTC,  "A",   0, "");
        add_row(lte_pkg::OP_XPUTC, "B",   0, "");
        add_row(lte_pkg::OP_XPUTC, 8'h0b, 0, "");
        add_row(lte_pkg::OP_XPUTC, 8'h0c, 0, "");
        add_row(lte_pkg::OP_PUTC,  8'h0a, 0, "");
        add_row(lte_pkg::OP_XPUTC, "\\",  0, "");

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_table[i])
        begin
            send_request(stim_table[i].op, stim_table[i].ch, stim_table[i].typed,
                         stim_table[i].text);
        end

        // Random requests over the idling phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            target = text_requests + ITEMS_PER_PHASE;
            while (text_requests < target)
            begin
                send_request(($urandom_range(1) == 0) ? lte_pkg::OP_PUTC : lte_pkg::OP_XPUTC,
                             pick_char(), 0, "");
            end
        end
        in_ch.valid = 1'b0;

        // Drain the remaining text, then watch for stray bytes.
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/lte_pkg.sv
src/lte_in_if.sv
src/lte_out_if.sv
src/lte_ctrl.sv
src/lte_datapath.sv
src/latex_text_escape_encoder_core.sv
bench/tb_latex_text_escape_encoder_core.sv
